@@ rtl/core/pkc_pkg.sv @@
package pkc_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int MAX_PARTS_DEF = 8;
  localparam logic [3:0] PART_COUNT_RESET = 4'd3;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic load;   // take the new byte, update palindrome bit, seed the OR wave
    logic shift;  // move the OR wave one cell toward cell 0
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

endpackage

@@ rtl/core/pkc_cell.sv @@
module pkc_cell #(
  parameter int MAX_LEN = pkc_pkg::MAX_LEN_DEF,
  parameter int MAX_PARTS = pkc_pkg::MAX_PARTS_DEF,
  parameter int IDX = 0,
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  logic                  clk,
  input  pkc_pkg::cell_ctl_t    ctl,
  input  logic [LW-1:0]         length,
  input  logic [7:0]            char_byte,
  input  logic                  pal_in,
  output logic                  pal,
  input  logic [MAX_PARTS-1:0]  wave_in,
  output logic [MAX_PARTS-1:0]  wave,
  input  logic                  split_we,
  input  logic [MAX_PARTS-1:0]  split_wdata
);

  logic [7:0]           chr;
  logic [MAX_PARTS-1:0] split;
  logic                 here;
  logic                 near;
  logic                 active;
  logic                 same;
  logic                 pal_new;

  // length is the position of the byte being added
  assign here    = (length == LW'(IDX));
  assign near    = (length == LW'(IDX + 1));
  assign active  = (LW'(IDX) <= length);
  assign same    = here | (chr == char_byte);
  // spans of one or two bytes need only the end match
  assign pal_new = same & (here | near | pal_in);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (here) begin
        chr <= char_byte;
      end
      pal  <= pal_new;
      wave <= (active && pal_new) ? split : '0;
    end else if (ctl.shift) begin
      wave <= wave | wave_in;
    end
    if (split_we) begin
      split <= split_wdata;
    end
  end

endmodule

@@ rtl/core/palindrome_k_partition_check_unit.sv @@
// Palindrome k-partition check.
// Input channel: one character per beat on char_byte, last_char high on the
// final character of a string. Output channel: one beat per string, carrying
// splittable (string splits into exactly part_count palindromes) and too_long
// (string had more than MAX_LEN characters; splittable is then 0).
// part_count is written with cfg_wen; the user must do so only while the
// block is idle, as the block does not enforce it; reset value 3. A row of
// MAX_LEN cells holds the characters, the palindrome column and the split
// table. On a beat every cell updates its palindrome bit at once; the OR
// over all starting positions then travels down the cell chain, one cell per
// cycle. A character at position p (from 0) keeps in_stall high after its
// beat while the wave travels from cell p to cell 0, then for its finish
// step; a dropped character of an overlong string has only the finish step.
// If the output beat is stalled when a new result is due, the block holds
// (in_stall stays high) until the waiting beat is taken.
// Reset (rst, synchronous) empties the string and the output; the stores
// themselves need no clearing.
module palindrome_k_partition_check_unit #(
  parameter int MAX_LEN = pkc_pkg::MAX_LEN_DEF,
  parameter int MAX_PARTS = pkc_pkg::MAX_PARTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_byte,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       splittable,
  output logic       too_long,
  input  logic       cfg_wen,
  input  logic [3:0] part_count
);

  localparam int LW = $clog2(MAX_LEN + 1);

  pkc_pkg::state_t    state;
  pkc_pkg::cell_ctl_t ctl;
  logic [LW-1:0]      length;
  logic [LW-1:0]      rem;
  logic               ovf;
  logic               last_hold;
  logic               drop_hold;
  logic [3:0]         parts;

  logic                 accept;
  logic                 full;
  logic                 finish;
  logic                 fin_wr;
  logic                 ok;
  logic [MAX_PARTS-1:0] acc;
  logic [MAX_PARTS-1:0] split_wdata;

  logic                 pal_a  [MAX_LEN+1];
  logic [MAX_PARTS-1:0] wave_a [MAX_LEN+1];

  assign in_stall = (state != pkc_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (length == LW'(MAX_LEN));

  assign ctl = '{load:  accept && !full,
                 shift: (state == pkc_pkg::S_RUN) && (rem != '0)};

  // hold a string's final finish step while a previous result still waits
  assign finish = (state == pkc_pkg::S_RUN) && (rem == '0) &&
                  (!last_hold || !out_valid || !out_stall);
  assign fin_wr = finish && !drop_hold;

  assign acc         = wave_a[0];
  assign split_wdata = MAX_PARTS'({acc, 1'b0});

  assign ok = !ovf && (parts != 4'd0) && (int'(parts) <= MAX_PARTS) &&
              (|(acc & (MAX_PARTS'(1) << (parts - 4'd1))));

  assign pal_a[MAX_LEN]  = 1'b0;
  assign wave_a[MAX_LEN] = '0;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    logic                 we;
    logic [MAX_PARTS-1:0] wd;
    if (j == 0) begin : g_first
      // the empty prefix splits into zero parts
      assign we = 1'b1;
      assign wd = MAX_PARTS'(1);
    end else begin : g_rest
      assign we = fin_wr && (length == LW'(j - 1));
      assign wd = split_wdata;
    end
    pkc_cell #(
      .MAX_LEN   (MAX_LEN),
      .MAX_PARTS (MAX_PARTS),
      .IDX       (j)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .length      (length),
      .char_byte   (char_byte),
      .pal_in      (pal_a[j+1]),
      .pal         (pal_a[j]),
      .wave_in     (wave_a[j+1]),
      .wave        (wave_a[j]),
      .split_we    (we),
      .split_wdata (wd)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pkc_pkg::S_IDLE;
      length    <= '0;
      rem       <= '0;
      ovf       <= 1'b0;
      last_hold <= 1'b0;
      drop_hold <= 1'b0;
      out_valid <= 1'b0;
      parts     <= pkc_pkg::PART_COUNT_RESET;
    end else begin
      if (cfg_wen) begin
        parts <= part_count;
      end
      if (out_valid && !out_stall && !(finish && last_hold)) begin
        out_valid <= 1'b0;
      end
      case (state)
        pkc_pkg::S_IDLE: begin
          if (accept) begin
            rem       <= full ? '0 : length;
            last_hold <= last_char;
            drop_hold <= full;
            if (full) begin
              ovf <= 1'b1;
            end
            state <= pkc_pkg::S_RUN;
          end
        end
        pkc_pkg::S_RUN: begin
          if (rem != '0) begin
            rem <= rem - LW'(1);
          end else if (finish) begin
            if (last_hold) begin
              out_valid <= 1'b1;
              length    <= '0;
              ovf       <= 1'b0;
            end else if (!drop_hold) begin
              length <= length + LW'(1);
            end
            state <= pkc_pkg::S_IDLE;
          end
        end
        default: begin
          state <= pkc_pkg::S_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded with the beat
  always_ff @(posedge clk) begin
    if (finish && last_hold) begin
      splittable <= ok;
      too_long   <= ovf;
    end
  end

endmodule

@@ test/palindrome_k_partition_check_unit_tb.sv @@
module palindrome_k_partition_check_unit_tb;

  localparam int LEN_CAP = pkc_pkg::MAX_LEN_DEF;
  localparam int PARTS_CAP = pkc_pkg::MAX_PARTS_DEF;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct {
    bit [7:0] ch;
    bit       fin;
  } char_beat_t;

  typedef struct {
    bit splittable;
    bit too_long;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_byte = 8'd0;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       splittable;
  logic       too_long;
  logic       cfg_wen = 1'b0;
  logic [3:0] part_count = pkc_pkg::PART_COUNT_RESET;

  palindrome_k_partition_check_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_byte (char_byte),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .splittable(splittable),
    .too_long  (too_long),
    .cfg_wen   (cfg_wen),
    .part_count(part_count)
  );

  char_beat_t pending_chars[$];
  verdict_t   verdict_q[$];
  bit [7:0]   draft[$];
  char_beat_t next_beat;
  int         in_gap;
  int         out_hold;
  int         cycles;
  int         mismatches;
  bit         no_idle;

  // split predictor state
  bit [7:0]         seen_bytes[LEN_CAP];
  bit               pal_bits[LEN_CAP][LEN_CAP];
  bit [PARTS_CAP:0] split_rows[LEN_CAP+1];
  int               str_len;
  bit               overflowed;
  bit [3:0]         want_parts = pkc_pkg::PART_COUNT_RESET;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic take_char(input bit [7:0] c, input bit fin);
    int p;
    bit same;
    bit [PARTS_CAP:0] row;
    verdict_t v;
    if (str_len >= LEN_CAP) begin
      overflowed = 1'b1;
    end else begin
      p = str_len;
      if (p == 0) split_rows[0] = (PARTS_CAP+1)'(1);
      seen_bytes[p] = c;
      for (int j = 0; j <= p; j++) begin
        same = (seen_bytes[j] == c);
        pal_bits[j][p] = (p - j <= 1) ? same : (same & pal_bits[j+1][p-1]);
      end
      row = '0;
      for (int k = 1; k <= PARTS_CAP; k++) begin
        for (int st = 0; st <= p; st++) begin
          if (pal_bits[st][p] && split_rows[st][k-1]) row[k] = 1'b1;
        end
      end
      split_rows[p+1] = row;
      str_len = p + 1;
    end
    if (fin) begin
      v.too_long = overflowed;
      v.splittable = 1'b0;
      if (!overflowed && want_parts >= 1 && want_parts <= PARTS_CAP)
        v.splittable = split_rows[str_len][want_parts];
      verdict_q.push_back(v);
      str_len = 0;
      overflowed = 1'b0;
    end
  endtask

  // driver: hold a stalled beat, otherwise advance to the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) take_char(char_byte, last_char);
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_chars.size() != 0) begin
        next_beat = pending_chars.pop_front();
        char_byte <= next_beat.ch;
        last_char <= next_beat.fin;
        in_valid <= 1'b1;
        in_gap <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check each result beat, then draw the stall for the next one
  always @(posedge clk) begin
    verdict_t want;
    int wait_n;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with nothing expected: splittable %0b too_long %0b",
                 splittable, too_long);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (splittable !== want.splittable) begin
            $error("splittable: expected %0b, got %0b", want.splittable, splittable);
            mismatches++;
          end
          if (too_long !== want.too_long) begin
            $error("too_long: expected %0b, got %0b", want.too_long, too_long);
            mismatches++;
          end
        end
      end
      if (out_hold != 0) begin
        out_hold <= out_hold - 1;
        out_stall <= (out_hold != 1);
      end else if (out_valid && !out_stall) begin
        wait_n = draw_wait();
        out_hold <= wait_n;
        out_stall <= (wait_n != 0);
      end
    end
  end

  task automatic queue_draft();
    char_beat_t b;
    foreach (draft[i]) begin
      b.ch = draft[i];
      b.fin = (i == draft.size() - 1);
      pending_chars.push_back(b);
    end
  endtask

  // long strings of two letters, mostly the first, so some still split
  task automatic make_long(input int n);
    bit [7:0] a0;
    bit [7:0] a1;
    a0 = 8'($urandom_range(0, 255));
    a1 = 8'($urandom_range(0, 255));
    draft.delete();
    repeat (n) draft.push_back(($urandom_range(0, 9) < 8) ? a0 : a1);
  endtask

  task automatic make_string();
    bit [7:0] alpha[3];
    bit [7:0] b;
    int kind;
    int n;
    int base;
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
    draft.delete();
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // concatenation of short palindromes
      repeat ($urandom_range(1, 9)) begin
        n = $urandom_range(1, 4);
        base = draft.size();
        repeat (n) draft.push_back(8'd0);
        for (int i = 0; i < (n + 1) / 2; i++) begin
          b = alpha[$urandom_range(0, 2)];
          draft[base+i] = b;
          draft[base+n-1-i] = b;
        end
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 8)) draft.push_back(alpha[$urandom_range(0, 1)]);
    end else if (kind < 98) begin
      repeat ($urandom_range(1, 12)) draft.push_back(8'($urandom_range(0, 255)));
    end else begin
      make_long($urandom_range(60, 70));
    end
  endtask

  task automatic write_parts(input bit [3:0] v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    part_count <= v;
    want_parts = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_chars.size() != 0 || in_valid || verdict_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int parts_plan[$];
    int phase_budget;
    int phase_items;
    parts_plan = '{0, 1, 8, 15, 2, 9, 4, 5, 6, 7, 3, 12};
    phase_budget = RANDOM_ITEMS / (parts_plan.size() + 1);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed strings at the reset part count
    draft = '{8'h00};
    queue_draft();
    draft = '{8'hff, 8'hff, 8'hff};
    queue_draft();
    draft = '{8'h61, 8'h62, 8'h61};
    queue_draft();
    draft = '{8'h00, 8'hff, 8'h00, 8'hff};
    queue_draft();
    draft = '{8'h01, 8'h80, 8'h7f, 8'h80, 8'h01};
    queue_draft();
    draft = '{8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa};
    queue_draft();
    wait_drain();

    // boundary and overflow strings
    no_idle = 1'b0;
    make_long(LEN_CAP);
    queue_draft();
    make_long(LEN_CAP + 1);
    queue_draft();
    draft.delete();
    repeat (LEN_CAP) draft.push_back(8'h61);
    queue_draft();
    wait_drain();

    for (int ph = 0; ph <= parts_plan.size(); ph++) begin
      if (ph < parts_plan.size()) write_parts(4'(parts_plan[ph]));
      else write_parts(4'($urandom_range(0, 15)));
      no_idle = (ph % 4 == 3);
      phase_items = 0;
      while (phase_items < phase_budget) begin
        make_string();
        queue_draft();
        phase_items += draft.size();
      end
      wait_drain();
    end

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pkc_pkg.sv
rtl/core/pkc_cell.sv
rtl/core/palindrome_k_partition_check_unit.sv
test/palindrome_k_partition_check_unit_tb.sv
